>>> rtl/e2q_pkg.sv
`timescale 1ns / 1ps

package e2q_pkg;

    localparam int MAX_STEPS    = 32;
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;
    localparam int FULL_TURN    = 46080;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } sincos_t;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    // Restoring division, one quotient bit per pass.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Alternating series for atan(1/5) or atan(1/239) in Q62.
    function automatic logic [63:0] atan_inv_q62(input logic use_239);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] k;
        p   = use_239 ? (64'd1 << 62) / 64'd239 : (64'd1 << 62) / 64'd5;
        sum = '0;
        k   = '0;
        while (p != 64'd0) begin
            term = udiv64(p, 2 * k + 64'd1);
            if (!k[0]) begin
                sum = sum + term;
            end else begin
                sum = sum - term;
            end
            p = use_239 ? p / 64'd57121 : p / 64'd25;
            k = k + 64'd1;
        end
        return sum;
    endfunction

    // Alternating series for atan(2^-i) in Q62, i at least one.
    function automatic logic [63:0] atan_pow2_q62(input int i);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] k;
        p   = 64'd1 << (62 - i);
        sum = '0;
        k   = '0;
        while (p != 64'd0) begin
            term = udiv64(p, 2 * k + 64'd1);
            if (!k[0]) begin
                sum = sum + term;
            end else begin
                sum = sum - term;
            end
            p = p >> (2 * i);
            k = k + 64'd1;
        end
        return sum;
    endfunction

    function automatic logic [63:0] quarter_pi_q62();
        return (atan_inv_q62(1'b0) << 2) - atan_inv_q62(1'b1);
    endfunction

    function automatic logic [63:0] atan_q30(input int i);
        logic [63:0] v;
        v = (i == 0) ? quarter_pi_q62() : atan_pow2_q62(i);
        return (v + (64'd1 << 31)) >> 32;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n    = n_in;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) begin
            bitv = bitv >> 2;
        end
        while (bitv != 64'd0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Reciprocal of the CORDIC gain for the given number of iterations, Q2.30.
    function automatic logic [63:0] gain_q30(input int steps);
        logic [63:0] k2;
        k2 = 64'd1 << 62;
        for (int i = 0; i < steps; i++) begin
            k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
        end
        return (isqrt64(k2) + 64'd1) >> 1;
    endfunction

    localparam logic [63:0] PI_Q46 = (quarter_pi_q62() + 64'd8192) >> 14;
    // Degrees to radians: pi / 23040 = pi / (45 * 2^9), split as 45 * Q + R.
    localparam logic [63:0] RAD_Q  = PI_Q46 / 64'd45;
    localparam logic [63:0] RAD_R  = PI_Q46 % 64'd45;
    localparam logic [20:0] RAD_QH = RAD_Q[42:22];
    localparam logic [21:0] RAD_QL = RAD_Q[21:0];
    localparam logic [5:0]  RAD_RM = RAD_R[5:0];

endpackage

>>> rtl/e2q_lane.sv
`timescale 1ns / 1ps

module e2q_lane import e2q_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [15:0]  angle,
    output sincos_t             sincos
);

    localparam int XW = 34;
    localparam int ZW = 33;
    localparam logic signed [17:0] HT = 18'(HALF_TURN);
    localparam logic signed [17:0] QT = 18'(QUARTER_TURN);
    localparam logic signed [17:0] FT = 18'(FULL_TURN);
    localparam logic signed [XW-1:0] GAIN = XW'(gain_q30(STEPS));

    logic signed [15:0] ang_reg;

    logic signed [17:0] h_a;
    logic signed [17:0] h_b;
    logic signed [17:0] h_c;
    logic signed [17:0] h_abs;
    logic               negc_next;
    logic [13:0]        mag_reg;
    logic               neg1_reg;
    logic               nc1_reg;

    logic [34:0]        ph_reg;
    logic [35:0]        pl_reg;
    logic [19:0]        mr_reg;
    logic               neg2_reg;
    logic               nc2_reg;

    logic [56:0]        a_sum;
    logic [24:0]        def;
    logic [30:0]        def45;
    logic               carry;
    logic [31:0]        rad;
    logic signed [ZW-1:0] z3_next;
    logic signed [ZW-1:0] z3_reg;
    logic               nc3_reg;

    logic signed [XW-1:0] x_reg [STEPS];
    logic signed [XW-1:0] y_reg [STEPS];
    logic signed [ZW-1:0] z_reg [STEPS-1];
    logic                 nc_reg [STEPS];

    logic signed [XW-1:0] cos_full;
    sincos_t              sc_next;
    sincos_t              sc_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= angle;
        end
    end

    // Wrap the half angle into one turn, then fold it into a right angle.
    always_comb begin
        h_a = {{2{ang_reg[15]}}, ang_reg};
        if (h_a >= HT) begin
            h_b = h_a - FT;
        end else if (h_a < -HT) begin
            h_b = h_a + FT;
        end else begin
            h_b = h_a;
        end
        negc_next = 1'b0;
        h_c = h_b;
        if (h_b > QT) begin
            h_c = HT - h_b;
            negc_next = 1'b1;
        end else if (h_b < -QT) begin
            h_c = -HT - h_b;
            negc_next = 1'b1;
        end
        h_abs = h_c[17] ? -h_c : h_c;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= h_abs[13:0];
            neg1_reg <= h_c[17];
            nc1_reg  <= negc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg   <= 35'(mag_reg) * 35'(RAD_QH);
            pl_reg   <= 36'(mag_reg) * 36'(RAD_QL);
            mr_reg   <= 20'(mag_reg) * 20'(RAD_RM);
            neg2_reg <= neg1_reg;
            nc2_reg  <= nc1_reg;
        end
    end

    // The low 25 bits of mag*Q together with mag*R/45 decide the rounding
    // carry; it is set when 45*(low + 2^24) + mag*R reaches 45*2^25.
    always_comb begin
        a_sum = {ph_reg, 22'd0} + 57'(pl_reg);
        def   = 25'(25'd1 << 24) - a_sum[24:0];
        def45 = 31'(def) * 31'(45);
        carry = a_sum[24] || ({11'd0, mr_reg} >= def45);
        rad   = a_sum[56:25] + 32'(carry);
        z3_next = neg2_reg ? -$signed({1'b0, rad}) : $signed({1'b0, rad});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z3_reg  <= z3_next;
            nc3_reg <= nc2_reg;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_iter
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(atan_q30(i));
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic                 nc_in;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;

        if (i == 0) begin : g_first
            assign x_in  = GAIN;
            assign y_in  = '0;
            assign z_in  = z3_reg;
            assign nc_in = nc3_reg;
        end else begin : g_chain
            assign x_in  = x_reg[i-1];
            assign y_in  = y_reg[i-1];
            assign z_in  = z_reg[i-1];
            assign nc_in = nc_reg[i-1];
        end

        assign xs     = x_in >>> i;
        assign ys     = y_in >>> i;
        assign x_next = (z_in >= 0) ? x_in - ys : x_in + ys;
        assign y_next = (z_in >= 0) ? y_in + xs : y_in - xs;

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i]  <= x_next;
                y_reg[i]  <= y_next;
                nc_reg[i] <= nc_in;
            end
        end

        if (i < STEPS - 1) begin : g_angle
            logic signed [ZW-1:0] z_next;
            assign z_next = (z_in >= 0) ? z_in - ATAN_I : z_in + ATAN_I;
            always_ff @(posedge aclk) begin
                if (en) begin
                    z_reg[i] <= z_next;
                end
            end
        end
    end

    always_comb begin
        cos_full  = nc_reg[STEPS-1] ? -x_reg[STEPS-1] : x_reg[STEPS-1];
        sc_next.s = y_reg[STEPS-1][31:0];
        sc_next.c = cos_full[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg <= sc_next;
        end
    end

    assign sincos = sc_reg;

endmodule

>>> rtl/e2q_merge.sv
`timescale 1ns / 1ps

module e2q_merge import e2q_pkg::*; (
    input  logic    aclk,
    input  logic    en,
    input  sincos_t roll,
    input  sincos_t pitch,
    input  sincos_t yaw,
    output quat_t   quat
);

    localparam logic signed [63:0] RND29 = 64'sh0000_0000_2000_0000;
    localparam logic signed [63:0] RND45 = 64'sh0000_2000_0000_0000;

    logic signed [63:0] pcc_reg;
    logic signed [63:0] pss_reg;
    logic signed [63:0] psc_reg;
    logic signed [63:0] pcs_reg;
    logic signed [31:0] cy0_reg;
    logic signed [31:0] sy0_reg;

    logic signed [63:0] tcc;
    logic signed [63:0] tss;
    logic signed [63:0] tsc;
    logic signed [63:0] tcs;
    logic signed [31:0] cc_reg;
    logic signed [31:0] ss_reg;
    logic signed [31:0] sc_reg;
    logic signed [31:0] cs_reg;
    logic signed [31:0] cy1_reg;
    logic signed [31:0] sy1_reg;

    logic signed [63:0] cc_cy_reg;
    logic signed [63:0] ss_sy_reg;
    logic signed [63:0] sc_cy_reg;
    logic signed [63:0] cs_sy_reg;
    logic signed [63:0] cs_cy_reg;
    logic signed [63:0] sc_sy_reg;
    logic signed [63:0] cc_sy_reg;
    logic signed [63:0] ss_cy_reg;

    quat_t q_next;
    quat_t q_reg;

    function automatic logic signed [15:0] to_q14(input logic signed [63:0] sum);
        logic signed [63:0] t;
        logic signed [17:0] v;
        t = sum + RND45;
        v = t[63:46];
        if (v > 18'sd16384) begin
            return 16'sd16384;
        end else if (v < -18'sd16384) begin
            return -16'sd16384;
        end
        return v[15:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            pcc_reg <= 64'(roll.c) * 64'(pitch.c);
            pss_reg <= 64'(roll.s) * 64'(pitch.s);
            psc_reg <= 64'(roll.s) * 64'(pitch.c);
            pcs_reg <= 64'(roll.c) * 64'(pitch.s);
            cy0_reg <= yaw.c;
            sy0_reg <= yaw.s;
        end
    end

    // Pair products go back to Q30 with rounding.
    always_comb begin
        tcc = pcc_reg + RND29;
        tss = pss_reg + RND29;
        tsc = psc_reg + RND29;
        tcs = pcs_reg + RND29;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cc_reg  <= tcc[61:30];
            ss_reg  <= tss[61:30];
            sc_reg  <= tsc[61:30];
            cs_reg  <= tcs[61:30];
            cy1_reg <= cy0_reg;
            sy1_reg <= sy0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cc_cy_reg <= 64'(cc_reg) * 64'(cy1_reg);
            ss_sy_reg <= 64'(ss_reg) * 64'(sy1_reg);
            sc_cy_reg <= 64'(sc_reg) * 64'(cy1_reg);
            cs_sy_reg <= 64'(cs_reg) * 64'(sy1_reg);
            cs_cy_reg <= 64'(cs_reg) * 64'(cy1_reg);
            sc_sy_reg <= 64'(sc_reg) * 64'(sy1_reg);
            cc_sy_reg <= 64'(cc_reg) * 64'(sy1_reg);
            ss_cy_reg <= 64'(ss_reg) * 64'(cy1_reg);
        end
    end

    always_comb begin
        q_next.w = to_q14(cc_cy_reg + ss_sy_reg);
        q_next.x = to_q14(sc_cy_reg - cs_sy_reg);
        q_next.y = to_q14(cs_cy_reg + sc_sy_reg);
        q_next.z = to_q14(cc_sy_reg - ss_cy_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign quat = q_reg;

endmodule

>>> rtl/euler_to_quaternion.sv
// Throughput: one word per cycle while the skid buffer is empty; each CORDIC iteration has a
// pipeline stage of its own in each of the three angle lanes, so the stage count follows
// CORDIC_STEPS, capped at MAX_STEPS.
// The output register and a one-word skid buffer let the pipeline keep accepting while
// a result waits. Reset clears the valid bits only; there are no tables to initialize.
`timescale 1ns / 1ps

module euler_to_quaternion import e2q_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_roll_deg,
    input  logic signed [15:0] s_pitch_deg,
    input  logic signed [15:0] s_yaw_deg,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_qw,
    output logic signed [15:0] m_qx,
    output logic signed [15:0] m_qy,
    output logic signed [15:0] m_qz
);

    localparam int STEPS_USED = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
    localparam int NSTG       = STEPS_USED + 9;

    logic            en;
    logic [NSTG-1:0] valid_reg;
    logic            pipe_done;
    sincos_t         sc_roll;
    sincos_t         sc_pitch;
    sincos_t         sc_yaw;
    quat_t           q_pipe;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic            skid_valid_reg;
    logic            skid_valid_next;
    quat_t           out_reg;
    quat_t           out_next;
    quat_t           skid_reg;
    quat_t           skid_next;

    // The whole pipeline moves together and stops only while the skid word is held.
    assign en        = !skid_valid_reg;
    assign s_ready   = en;
    assign pipe_done = valid_reg[NSTG-1] && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NSTG-2:0], s_valid};
        end
    end

    e2q_lane #(.STEPS(STEPS_USED)) u_lane_roll (
        .aclk   (aclk),
        .en     (en),
        .angle  (s_roll_deg),
        .sincos (sc_roll)
    );

    e2q_lane #(.STEPS(STEPS_USED)) u_lane_pitch (
        .aclk   (aclk),
        .en     (en),
        .angle  (s_pitch_deg),
        .sincos (sc_pitch)
    );

    e2q_lane #(.STEPS(STEPS_USED)) u_lane_yaw (
        .aclk   (aclk),
        .en     (en),
        .angle  (s_yaw_deg),
        .sincos (sc_yaw)
    );

    e2q_merge u_merge (
        .aclk  (aclk),
        .en    (en),
        .roll  (sc_roll),
        .pitch (sc_pitch),
        .yaw   (sc_yaw),
        .quat  (q_pipe)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (pipe_done) begin
            if (!out_valid_reg || m_ready) begin
                out_next       = q_pipe;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = q_pipe;
                skid_valid_next = 1'b1;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid = out_valid_reg;
    assign m_qw    = out_reg.w;
    assign m_qx    = out_reg.x;
    assign m_qy    = out_reg.y;
    assign m_qz    = out_reg.z;

endmodule

>>> sim/tb_euler_to_quaternion.sv
`timescale 1ns / 1ps

module tb_euler_to_quaternion;
    import e2q_pkg::*;

    localparam int  STEPS      = 16;
    localparam int  STEPS_USED = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;
    localparam int  LATENCY    = STEPS + 9;
    localparam int  HOLD_LEN   = 300;
    localparam int  HOLD_AT    = 250;
    localparam int  N_RANDOM   = 1030;

    // Which fields of a directed row carry a typed-in value.
    localparam logic [3:0] KNOWN_NONE = 4'b0000;
    localparam logic [3:0] KNOWN_W    = 4'b1000;
    localparam logic [3:0] KNOWN_X    = 4'b0100;
    localparam logic [3:0] KNOWN_Y    = 4'b0010;
    localparam logic [3:0] KNOWN_Z    = 4'b0001;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic [3:0]         known;
        quat_t              typed_q;
    } stim_row_t;

    localparam int N_ROWS = 18;

    stim_row_t directed_rows [N_ROWS] = '{
        '{16'sd0,      16'sd0,      16'sd0,      KNOWN_W, '{16384, 0, 0, 0}},
        '{16'sd11520,  16'sd0,      16'sd0,      KNOWN_X, '{0, 16384, 0, 0}},
        '{-16'sd11520, 16'sd0,      16'sd0,      KNOWN_X, '{0, -16384, 0, 0}},
        '{16'sd0,      16'sd11520,  16'sd0,      KNOWN_Y, '{0, 0, 16384, 0}},
        '{16'sd0,      16'sd0,      16'sd11520,  KNOWN_Z, '{0, 0, 0, 16384}},
        '{16'sd0,      16'sd0,      -16'sd11520, KNOWN_Z, '{0, 0, 0, -16384}},
        '{16'sd23040,  16'sd0,      16'sd0,      KNOWN_W, '{-16384, 0, 0, 0}},
        '{-16'sd23040, 16'sd0,      16'sd0,      KNOWN_W, '{-16384, 0, 0, 0}},
        '{16'sd0,      16'sd23040,  16'sd0,      KNOWN_W, '{-16384, 0, 0, 0}},
        '{16'sd0,      16'sd0,      -16'sd23040, KNOWN_W, '{-16384, 0, 0, 0}},
        '{16'sd23039,  -16'sd23039, 16'sd23041,  KNOWN_NONE, '{0, 0, 0, 0}},
        '{16'sd32767,  16'sd32767,  16'sd32767,  KNOWN_NONE, '{0, 0, 0, 0}},
        '{-16'sd32768, -16'sd32768, -16'sd32768, KNOWN_NONE, '{0, 0, 0, 0}},
        '{16'sd32767,  -16'sd32768, 16'sd0,      KNOWN_NONE, '{0, 0, 0, 0}},
        '{16'sd11521,  -16'sd11521, 16'sd11519,  KNOWN_NONE, '{0, 0, 0, 0}},
        '{16'sd5760,   16'sd5760,   16'sd5760,   KNOWN_NONE, '{0, 0, 0, 0}},
        '{-16'sd1,     16'sd1,      -16'sd1,     KNOWN_NONE, '{0, 0, 0, 0}},
        '{16'sd21845,  -16'sd21846, -16'sd32767, KNOWN_NONE, '{0, 0, 0, 0}}
    };

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_roll_deg  = '0;
    logic signed [15:0] s_pitch_deg = '0;
    logic signed [15:0] s_yaw_deg   = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic signed [15:0] m_qw;
    logic signed [15:0] m_qx;
    logic signed [15:0] m_qy;
    logic signed [15:0] m_qz;

    euler_to_quaternion #(.CORDIC_STEPS(STEPS)) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_roll_deg  (s_roll_deg),
        .s_pitch_deg (s_pitch_deg),
        .s_yaw_deg   (s_yaw_deg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_qw        (m_qw),
        .m_qx        (m_qx),
        .m_qy        (m_qy),
        .m_qz        (m_qz)
    );

    always #10 aclk = ~aclk;

    // CORDIC tables, rebuilt here from the series definitions.
    longint            atan_table [MAX_STEPS];
    longint            gain_k;
    longint unsigned   pi_q46;

    quat_t             pending_quats [$];
    int                mismatches  = 0;
    int                words_sent  = 0;
    logic              hold_active = 1'b0;
    bit                send_gappy  = 1'b1;

    function automatic longint unsigned atan_series(input longint unsigned p0,
                                                    input longint unsigned div);
        longint unsigned p;
        longint unsigned sum;
        longint unsigned k;
        p   = p0;
        sum = 0;
        k   = 0;
        while (p != 0) begin
            if (k[0] == 1'b0) begin
                sum = sum + p / (2 * k + 1);
            end else begin
                sum = sum - p / (2 * k + 1);
            end
            p = p / div;
            k = k + 1;
        end
        return sum;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n_in);
        longint unsigned n;
        longint unsigned root;
        longint unsigned probe;
        n     = n_in;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n) probe = probe >> 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    task automatic build_tables();
        longint unsigned one;
        longint unsigned quarter_pi;
        longint unsigned v;
        longint unsigned k2;
        one        = 64'd1 << 62;
        quarter_pi = 4 * atan_series(one / 5, 25) - atan_series(one / 239, 57121);
        pi_q46     = (quarter_pi + (64'd1 << 13)) >> 14;
        atan_table[0] = longint'((quarter_pi + (64'd1 << 31)) >> 32);
        for (int i = 1; i < MAX_STEPS; i++) begin
            v = atan_series(one >> i, 64'd1 << (2 * i));
            atan_table[i] = longint'((v + (64'd1 << 31)) >> 32);
        end
        k2 = one;
        for (int i = 0; i < STEPS_USED; i++) begin
            k2 = k2 - k2 / ((64'd1 << (2 * i)) + 1);
        end
        gain_k = longint'((int_sqrt(k2) + 1) >> 1);
    endtask

    // The input word read as a half angle in 1/128 degree, folded into +-90 degrees.
    task automatic half_sin_cos(input logic signed [15:0] a, output longint s,
                                output longint c);
        longint h;
        longint mag;
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        bit     flip;
        h    = longint'(a);
        flip = 1'b0;
        if (h >= HALF_TURN) begin
            h = h - FULL_TURN;
        end else if (h < -HALF_TURN) begin
            h = h + FULL_TURN;
        end
        if (h > QUARTER_TURN) begin
            h    = HALF_TURN - h;
            flip = 1'b1;
        end else if (h < -QUARTER_TURN) begin
            h    = -HALF_TURN - h;
            flip = 1'b1;
        end
        mag = (h < 0) ? -h : h;
        z   = longint'(((longint'(mag) * pi_q46) / longint'(HALF_TURN) + 64'd32768) >> 16);
        if (h < 0) z = -z;
        x = gain_k;
        y = 0;
        for (int i = 0; i < STEPS_USED; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_table[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_table[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endtask

    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [15:0] round_q14(input longint sum);
        longint v;
        v = (sum + (64'sd1 <<< 45)) >>> 46;
        if (v > 16384)  v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    task automatic predict_quat(input logic signed [15:0] roll, pitch, yaw,
                                output quat_t q);
        longint sr, cr, sp, cp, sy, cy;
        longint cc, ss, sc, cs;
        half_sin_cos(roll, sr, cr);
        half_sin_cos(pitch, sp, cp);
        half_sin_cos(yaw, sy, cy);
        cc  = mul_q30(cr, cp);
        ss  = mul_q30(sr, sp);
        sc  = mul_q30(sr, cp);
        cs  = mul_q30(cr, sp);
        q.w = round_q14(cc * cy + ss * sy);
        q.x = round_q14(sc * cy - cs * sy);
        q.y = round_q14(cs * cy + sc * sy);
        q.z = round_q14(cc * sy - ss * cy);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // Angles near the wrap and fold points are drawn more often than plain noise would.
    function automatic logic signed [15:0] rand_angle();
        int pick;
        int base;
        pick = $urandom_range(0, 9);
        if (pick < 6) return 16'($urandom);
        case ($urandom_range(0, 6))
            0: base = 0;
            1: base = QUARTER_TURN;
            2: base = -QUARTER_TURN;
            3: base = HALF_TURN;
            4: base = -HALF_TURN;
            5: base = 32767;
            default: base = -32768;
        endcase
        return 16'(base + $urandom_range(0, 8) - 4);
    endfunction

    task automatic send_word(input logic signed [15:0] roll, pitch, yaw,
                             input logic [3:0] known, input quat_t typed_q);
        quat_t q;
        int    gap;
        gap = 0;
        if (send_gappy && !hold_active && $urandom_range(0, 99) < 35) gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_roll_deg  <= roll;
        s_pitch_deg <= pitch;
        s_yaw_deg   <= yaw;
        do @(posedge aclk); while (!s_ready);
        predict_quat(roll, pitch, yaw, q);
        if (known & KNOWN_W) q.w = typed_q.w;
        if (known & KNOWN_X) q.x = typed_q.x;
        if (known & KNOWN_Y) q.y = typed_q.y;
        if (known & KNOWN_Z) q.z = typed_q.z;
        pending_quats.push_back(q);
        words_sent++;
    endtask

    task automatic check_field(input string name, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: random stalls, with quiet stretches, and the long hold-off.
    initial begin
        quat_t q;
        int    stall_left;
        int    cycle;
        bit    recv_gappy;
        stall_left = 0;
        cycle      = 0;
        recv_gappy = 1'b1;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_quats.size() == 0) begin
                    $error("result word with no expected value pending");
                    mismatches++;
                end else begin
                    q = pending_quats.pop_front();
                    check_field("qw", q.w, m_qw);
                    check_field("qx", q.x, m_qx);
                    check_field("qy", q.y, m_qy);
                    check_field("qz", q.z, m_qz);
                end
            end
            cycle++;
            if (cycle % 128 == 0) recv_gappy = ($urandom_range(0, 3) != 0);
            if (hold_active) begin
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (recv_gappy && $urandom_range(0, 99) < 30) stall_left = gap_len();
            end
        end
    end

    // Once traffic is flowing, the receiver holds off long enough to fill the pipeline.
    initial begin
        wait (words_sent >= HOLD_AT);
        @(posedge aclk);
        hold_active <= 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        hold_active <= 1'b0;
    end

    initial begin
        stim_row_t row;
        quat_t     none_q;
        none_q = '0;
        build_tables();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            row = directed_rows[i];
            send_word(row.roll, row.pitch, row.yaw, row.known, row.typed_q);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 64 == 0) send_gappy = ($urandom_range(0, 3) != 0);
            send_word(rand_angle(), rand_angle(), rand_angle(), KNOWN_NONE, none_q);
        end
        s_valid <= 1'b0;

        while (pending_quats.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> euler_to_quaternion.f
rtl/e2q_pkg.sv
rtl/e2q_lane.sv
rtl/e2q_merge.sv
rtl/euler_to_quaternion.sv
sim/tb_euler_to_quaternion.sv
